### src/dhsp_pkg.sv
// shared types and constants for the double hash server placement block
// no dependencies; used by the interfaces, controller, datapath and top level
package dhsp_pkg;

    localparam int MAX_SERVERS = 64;
    localparam int SRV_W       = 6;   // server index width
    localparam int CNT_W       = 7;   // server count width, holds MAX_SERVERS itself
    localparam int LOAD_W      = 10;  // per-server load and capacity width
    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 25;  // wide enough for 104729 * 255 + 123
    localparam int BIT_CNT_W   = 5;   // counts HASH_W remainder steps
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 10;

    localparam logic [HASH_W-1:0] HASH1_MUL = HASH_W'(7919);
    localparam logic [HASH_W-1:0] HASH2_MUL = HASH_W'(104729);
    localparam logic [HASH_W-1:0] HASH2_ADD = HASH_W'(123);
    localparam logic [BYTE_W-1:0] SKIP_BYTE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take_byte;
        logic hash_load;
        logic mod_step;
        logic probe_init;
        logic probe_read;
        logic probe_next;
        logic commit;
    } dhsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_last;
        logic found;
        logic last_probe;
        logic out_free;
    } dhsp_sts_t;

endpackage

### src/dhsp_req_if.sv
// request channel: one name byte per transfer
// depends on dhsp_pkg
interface dhsp_req_if;
    logic                       valid;
    logic                       ready;
    logic [dhsp_pkg::BYTE_W-1:0] name_byte;
    logic                       last_byte;

    modport source (output valid, output name_byte, output last_byte, input ready);
    modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

### src/dhsp_res_if.sv
// result channel: one placement outcome per request name
// depends on dhsp_pkg
interface dhsp_res_if;
    logic                       valid;
    logic                       ready;
    logic                       placed;
    logic [dhsp_pkg::SRV_W-1:0] server_index;
    logic [dhsp_pkg::SRV_W-1:0] home_server;
    logic                       redirected;

    modport source (output valid, output placed, output server_index,
                    output home_server, output redirected, input ready);
    modport sink   (input valid, input placed, input server_index,
                    input home_server, input redirected, output ready);
endinterface

### src/double_hash_server_placement_core.sv
// top level of the double hash server placement block
// depends on dhsp_pkg, dhsp_req_if, dhsp_res_if, dhsp_ctrl and dhsp_datapath
//
// usage:
//   request channel carries a name one byte per transfer (valid/ready),
//   last_byte marks the end of a name; space bytes do not enter the checksum
//   result channel returns one placement outcome per name (valid/ready)
//   configuration is a plain write port: index 0 server count, 1 capacity;
//   write only while no name is in flight
// timing:
//   a byte that is not last is taken in one cycle, back to back
//   the last byte starts a sequence: 1 cycle hash multiply, 25 cycles of
//   bit-serial remainder for both hashes, then 2 cycles per probe since the
//   load table has a registered read port; total about 27 + 2 * probes
//   cycles, probes from 1 up to the server count (64 at most)
//   the request side stays closed until the result is in the output register
// reset:
//   checksum, configuration (count 1, capacity 1) and every server load clear;
//   loads clear through per-entry valid bits, so no sweep is needed
// stalls:
//   one result waits in the output register; if the receiver still holds
//   the previous result, the block waits in its final probe step
module double_hash_server_placement_core (
    input  logic                              clk,
    input  logic                              rst_n,
    dhsp_req_if.sink                          request,
    dhsp_res_if.source                        result,
    input  logic                              cfg_we,
    input  logic [dhsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dhsp_pkg::CFG_W-1:0]        cfg_wdata
);

    dhsp_pkg::dhsp_cmd_t cmd;
    dhsp_pkg::dhsp_sts_t sts;

    // sequencer: owns request ready and all step commands
    dhsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_last  (request.last_byte),
        .req_ready (request.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic, load table and result register
    dhsp_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .name_byte        (request.name_byte),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .res_valid        (result.valid),
        .res_ready        (result.ready),
        .res_placed       (result.placed),
        .res_server_index (result.server_index),
        .res_home_server  (result.home_server),
        .res_redirected   (result.redirected)
    );

endmodule

### src/dhsp_ctrl.sv
// sequencing state machine for hashing, remainder and probing
// depends on dhsp_pkg
module dhsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_last,
    output logic                req_ready,
    input  dhsp_pkg::dhsp_sts_t sts,
    output dhsp_pkg::dhsp_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_HASH  = 5'b00010,
        ST_MOD   = 5'b00100,
        ST_READ  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.take_byte = req_valid;
                if (req_valid && req_last)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash_load = 1'b1;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    cmd.probe_init = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.probe_read = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK:
            begin
                // placed or out of probes: finish once the result slot is free
                if (sts.found || sts.last_probe)
                begin
                    if (sts.out_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/dhsp_datapath.sv
// checksum, hash multipliers, bit-serial remainder, load table and result register
// depends on dhsp_pkg
module dhsp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dhsp_pkg::dhsp_cmd_t               cmd,
    output dhsp_pkg::dhsp_sts_t               sts,
    input  logic [dhsp_pkg::BYTE_W-1:0]       name_byte,
    input  logic                              cfg_we,
    input  logic [dhsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dhsp_pkg::CFG_W-1:0]        cfg_wdata,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              res_placed,
    output logic [dhsp_pkg::SRV_W-1:0]        res_server_index,
    output logic [dhsp_pkg::SRV_W-1:0]        res_home_server,
    output logic                              res_redirected
);

    localparam int SRV_W  = dhsp_pkg::SRV_W;
    localparam int CNT_W  = dhsp_pkg::CNT_W;
    localparam int LOAD_W = dhsp_pkg::LOAD_W;
    localparam int HASH_W = dhsp_pkg::HASH_W;
    localparam int MAX_SERVERS = dhsp_pkg::MAX_SERVERS;

    // configuration
    logic [CNT_W-1:0]  server_count_reg;
    logic [LOAD_W-1:0] capacity_reg;
    logic [CNT_W-1:0]  servers;

    // hashing and remainder
    logic [dhsp_pkg::BYTE_W-1:0]    checksum_reg;
    logic [HASH_W-1:0]              h1_reg;
    logic [HASH_W-1:0]              h2_reg;
    logic [SRV_W-1:0]               rem1_reg;
    logic [SRV_W-1:0]               rem2_reg;
    logic [dhsp_pkg::BIT_CNT_W-1:0] bit_cnt_reg;
    logic [CNT_W-1:0]               part1;
    logic [CNT_W-1:0]               part2;
    logic [SRV_W-1:0]               rem1_next;
    logic [SRV_W-1:0]               rem2_next;

    // probing
    logic [SRV_W-1:0]  idx_reg;
    logic [SRV_W-1:0]  probe_cnt_reg;
    logic [CNT_W-1:0]  idx_sum;
    logic [SRV_W-1:0]  idx_next;
    logic [LOAD_W-1:0] load_mem [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] load_valid_reg;
    logic [LOAD_W-1:0] rd_load_reg;
    logic              rd_valid_reg;
    logic [LOAD_W-1:0] cur_load;

    // effective server count: zero reads as one, above the table saturates
    always_comb
    begin
        priority if (server_count_reg == '0)
        begin
            servers = CNT_W'(1);
        end
        else if (server_count_reg > CNT_W'(MAX_SERVERS))
        begin
            servers = CNT_W'(MAX_SERVERS);
        end
        else
        begin
            servers = server_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg <= CNT_W'(1);
            capacity_reg     <= LOAD_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dhsp_pkg::CFG_SERVER_COUNT: server_count_reg <= cfg_wdata[CNT_W-1:0];
                dhsp_pkg::CFG_CAPACITY:     capacity_reg     <= cfg_wdata[LOAD_W-1:0];
                default:                    capacity_reg     <= capacity_reg;
            endcase
        end
    end

    // restoring remainder, one dividend bit per step on both hashes
    assign part1     = {rem1_reg, h1_reg[HASH_W-1]};
    assign part2     = {rem2_reg, h2_reg[HASH_W-1]};
    assign rem1_next = (part1 >= servers) ? SRV_W'(part1 - servers) : SRV_W'(part1);
    assign rem2_next = (part2 >= servers) ? SRV_W'(part2 - servers) : SRV_W'(part2);

    // next probe: both terms below the count, so one subtract wraps it
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, rem2_reg};
    assign idx_next = (idx_sum >= servers) ? SRV_W'(idx_sum - servers) : SRV_W'(idx_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checksum_reg <= '0;
        end
        else if (cmd.hash_load)
        begin
            checksum_reg <= '0;
        end
        else if (cmd.take_byte && (name_byte != dhsp_pkg::SKIP_BYTE))
        begin
            checksum_reg <= checksum_reg ^ name_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_load)
        begin
            h1_reg      <= HASH_W'(checksum_reg) * dhsp_pkg::HASH1_MUL;
            h2_reg      <= HASH_W'(checksum_reg) * dhsp_pkg::HASH2_MUL + dhsp_pkg::HASH2_ADD;
            rem1_reg    <= '0;
            rem2_reg    <= '0;
            bit_cnt_reg <= dhsp_pkg::BIT_CNT_W'(HASH_W - 1);
        end
        else if (cmd.mod_step)
        begin
            h1_reg      <= {h1_reg[HASH_W-2:0], 1'b0};
            h2_reg      <= {h2_reg[HASH_W-2:0], 1'b0};
            rem1_reg    <= rem1_next;
            rem2_reg    <= rem2_next;
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
    end

    // probing starts at home once the last remainder step lands
    always_ff @(posedge clk)
    begin
        if (cmd.mod_step && (bit_cnt_reg == '0))
        begin
            idx_reg       <= rem1_next;
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe_init)
        begin
            idx_reg       <= rem1_reg;
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            idx_reg       <= idx_next;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
    end

    assign cur_load = rd_valid_reg ? rd_load_reg : '0;

    // load table: registered read, written on a successful placement
    always_ff @(posedge clk)
    begin
        if (cmd.probe_read)
        begin
            rd_load_reg <= load_mem[idx_reg];
        end
        if (cmd.commit && sts.found)
        begin
            load_mem[idx_reg] <= cur_load + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.probe_read)
            begin
                rd_valid_reg <= load_valid_reg[idx_reg];
            end
            if (cmd.commit && sts.found)
            begin
                load_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_valid <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_placed       <= sts.found;
            res_server_index <= sts.found ? idx_reg : '0;
            res_home_server  <= rem1_reg;
            res_redirected   <= sts.found && (idx_reg != rem1_reg);
        end
    end

    assign sts.mod_last   = (bit_cnt_reg == '0);
    assign sts.found      = (cur_load < capacity_reg);
    assign sts.last_probe = (({1'b0, probe_cnt_reg} + CNT_W'(1)) == servers);
    assign sts.out_free   = !res_valid || res_ready;

endmodule

### tb/double_hash_server_placement_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the double hash server placement core
// depends on dhsp_pkg, dhsp_req_if, dhsp_res_if and double_hash_server_placement_core
module double_hash_server_placement_core_tb;

    localparam int BYTE_W      = dhsp_pkg::BYTE_W;
    localparam int SRV_W       = dhsp_pkg::SRV_W;
    localparam int CNT_W       = dhsp_pkg::CNT_W;
    localparam int LOAD_W      = dhsp_pkg::LOAD_W;
    localparam int CFG_IDX_W   = dhsp_pkg::CFG_IDX_W;
    localparam int CFG_W       = dhsp_pkg::CFG_W;
    localparam int MAX_SERVERS = dhsp_pkg::MAX_SERVERS;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 11;
    localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES     = 200;   // beyond hash, remainder and 64 probes
    localparam int SETTLE_CYCLES    = 8;     // quiet time before a register write
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_BYTES      = 105;
    localparam int PRESSURE_PHASE   = 8;

    // hashing constants of the placement scheme
    localparam longint unsigned H1_FACTOR  = 7919;
    localparam longint unsigned H2_FACTOR  = 104729;
    localparam longint unsigned H2_OFFSET  = 123;
    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

    typedef struct {
        logic [BYTE_W-1:0] name_byte;
        logic              last_byte;
    } name_byte_t;

    typedef struct {
        logic             placed;
        logic [SRV_W-1:0] server_index;
        logic [SRV_W-1:0] home_server;
        logic             redirected;
    } placement_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    dhsp_req_if request_ch ();
    dhsp_res_if result_ch ();

    double_hash_server_placement_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // placement predictor state: registers, checksum and per-server loads
    logic [CNT_W-1:0]  pred_server_count;
    logic [LOAD_W-1:0] pred_capacity;
    logic [BYTE_W-1:0] pred_checksum;
    logic [LOAD_W-1:0] pred_load [MAX_SERVERS];

    name_byte_t pending_bytes [$];        // request bytes not yet accepted
    placement_t expected_placements [$];  // predicted outcomes in order

    int bytes_offered;
    int bytes_accepted;
    int bytes_queued;
    int names_queued;
    int settings_used;
    int names_placed;
    int names_rejected;
    int names_redirected;
    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;   // bumped by the stimulus to ask for a long receiver stall
    int hold_served;
    int hold_left;
    int quiet_cycles;

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // one request byte into the predictor; returns 1 when the name completes
    function automatic bit predict_placement(input name_byte_t req, output placement_t outcome);
        longint unsigned servers;
        longint unsigned h1;
        longint unsigned h2;
        longint unsigned slot;
        longint unsigned probe;
        longint unsigned home;
        longint unsigned chosen;
        bit found;
        outcome.placed       = 1'b0;
        outcome.server_index = '0;
        outcome.home_server  = '0;
        outcome.redirected   = 1'b0;
        // spaces never enter the checksum, even on the last byte
        if (req.name_byte != SPACE_CHAR)
            pred_checksum = pred_checksum ^ req.name_byte;
        if (!req.last_byte)
            return 1'b0;
        // zero servers acts as one, anything past the table saturates
        if (pred_server_count == 0)
            servers = 1;
        else if (pred_server_count > MAX_SERVERS)
            servers = MAX_SERVERS;
        else
            servers = pred_server_count;
        h1     = H1_FACTOR * pred_checksum;
        h2     = H2_FACTOR * pred_checksum + H2_OFFSET;
        home   = h1 % servers;
        chosen = 0;
        found  = 1'b0;
        // double hashing walk, first server under capacity wins
        for (probe = 0; probe < servers && !found; probe++)
        begin
            slot = (h1 + probe * h2) % servers;
            if (pred_load[SRV_W'(slot)] < pred_capacity)
            begin
                pred_load[SRV_W'(slot)] = pred_load[SRV_W'(slot)] + 1'b1;
                chosen = slot;
                found  = 1'b1;
            end
        end
        pred_checksum        = '0;
        outcome.placed       = found;
        outcome.server_index = SRV_W'(chosen);
        outcome.home_server  = SRV_W'(home);
        outcome.redirected   = found && (chosen != home);
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // request side: accepted bytes go through the predictor at the rising edge
    always @(posedge clk)
    begin : request_accept
        name_byte_t req;
        placement_t outcome;
        if (rst_n && request_ch.valid && request_ch.ready)
        begin
            req = pending_bytes.pop_front();
            if (predict_placement(req, outcome))
                expected_placements.push_back(outcome);
            bytes_accepted++;
        end
    end

    // request side: offer the next byte at the falling edge, hold it until taken
    always @(negedge clk)
    begin : request_driver
        name_byte_t next_req;
        if (rst_n && !(request_ch.valid && bytes_offered != bytes_accepted))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = pending_bytes[0];
                request_ch.valid     <= 1'b1;
                request_ch.name_byte <= next_req.name_byte;
                request_ch.last_byte <= next_req.last_byte;
                bytes_offered++;
            end
            else
                request_ch.valid <= 1'b0;
        end
    end

    // result side: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        placement_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_placements.size() == 0)
            begin
                $error("unexpected result: placed %0d server %0d home %0d",
                       result_ch.placed, result_ch.server_index, result_ch.home_server);
                error_count++;
            end
            else
            begin
                want = expected_placements.pop_front();
                check_field("placed", 32'(want.placed), 32'(result_ch.placed));
                check_field("server_index", 32'(want.server_index),
                            32'(result_ch.server_index));
                check_field("home_server", 32'(want.home_server),
                            32'(result_ch.home_server));
                check_field("redirected", 32'(want.redirected), 32'(result_ch.redirected));
                if (want.placed)
                    names_placed++;
                else
                    names_rejected++;
                if (want.redirected)
                    names_redirected++;
            end
        end
    end

    // result side: random back-pressure, plus the long stall on request
    always @(negedge clk)
    begin : result_ready_driver
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog: too long with nothing moving on either channel
    always @(posedge clk)
    begin : watchdog
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_placements.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] value, input logic last_flag);
        name_byte_t req;
        req.name_byte = value;
        req.last_byte = last_flag;
        pending_bytes.push_back(req);
        bytes_queued++;
        if (last_flag)
            names_queued++;
    endtask

    // mostly short names, now and then a long one; spaces sprinkled in
    task automatic queue_random_name();
        int len;
        logic [BYTE_W-1:0] value;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            value = ($urandom_range(0, 6) == 0) ? SPACE_CHAR : BYTE_W'($urandom_range(0, 255));
            queue_byte(value, i == len - 1);
        end
    endtask

    // register write at the falling edge; predictor keeps the bits the register holds
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == dhsp_pkg::CFG_SERVER_COUNT)
            pred_server_count = CNT_W'(value);
        else
            pred_capacity = LOAD_W'(value);
    endtask

    task automatic write_setting(input int server_count, input int capacity_value);
        write_register(dhsp_pkg::CFG_SERVER_COUNT, server_count);
        write_register(dhsp_pkg::CFG_CAPACITY, capacity_value);
        settings_used++;
    endtask

    // every queued byte accepted and every result back, then a quiet stretch
    task automatic drain_phase();
        while (pending_bytes.size() != 0 || expected_placements.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int pick;
        int count_value;
        int capacity_value;
        int phase_start;

        // known values everywhere before the first edge
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = dhsp_pkg::CFG_SERVER_COUNT;
        cfg_wdata            = '0;
        request_ch.valid     = 1'b0;
        request_ch.name_byte = '0;
        request_ch.last_byte = 1'b0;
        result_ch.ready      = 1'b0;
        bytes_offered        = 0;
        bytes_accepted       = 0;
        bytes_queued         = 0;
        names_queued         = 0;
        settings_used        = 1;
        names_placed         = 0;
        names_rejected       = 0;
        names_redirected     = 0;
        error_count          = 0;
        hold_requests        = 0;
        hold_served          = 0;
        hold_left            = 0;
        quiet_cycles         = 0;
        send_idle_pct        = 19;
        recv_idle_pct        = 64;

        // predictor matches the block after reset: one server, capacity one
        pred_server_count = CNT_W'(1);
        pred_capacity     = LOAD_W'(1);
        pred_checksum     = '0;
        for (int i = 0; i < MAX_SERVERS; i++)
            pred_load[i] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: first name fills server 0, a space-only name is rejected
        queue_byte(8'h41, 1'b1);
        queue_byte(SPACE_CHAR, 1'b1);
        drain_phase();

        // widest table and deepest servers
        write_setting(MAX_SERVERS, 1023);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b1);
        queue_byte(SPACE_CHAR, 1'b0);      // name of spaces only
        queue_byte(SPACE_CHAR, 1'b1);
        queue_byte(8'h12, 1'b0);           // space in the middle
        queue_byte(SPACE_CHAR, 1'b0);
        queue_byte(8'h34, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h7F, 1'b0);           // last byte is a space
        queue_byte(SPACE_CHAR, 1'b1);
        drain_phase();

        // capacity zero rejects, home server still reported
        write_setting(MAX_SERVERS, 0);
        queue_byte(8'h5A, 1'b1);
        drain_phase();

        // server count zero acts as a single server
        write_setting(0, 2);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h02, 1'b1);
        queue_byte(8'h03, 1'b1);
        drain_phase();

        // all-ones count saturates to the full table
        write_setting(10'h3FF, 1023);
        queue_byte(8'hC3, 1'b1);
        queue_byte(8'h3C, 1'b1);
        drain_phase();

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < RANDOM_PHASES / 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 64;
            end
            else if (phase < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // server count: extremes, zero, raw values past the table, or anything
            pick = $urandom_range(0, 7);
            if (pick == 0)
                count_value = 1;
            else if (pick == 1)
                count_value = MAX_SERVERS;
            else if (pick == 2)
                count_value = 0;
            else if (pick == 3)
                count_value = $urandom_range(65, 1023);
            else
                count_value = $urandom_range(1, MAX_SERVERS);

            // capacity: mostly tiny so servers fill and rejections show up
            pick = $urandom_range(0, 9);
            if (pick == 0)
                capacity_value = 0;
            else if (pick == 1)
                capacity_value = 1023;
            else if (pick == 2)
                capacity_value = $urandom_range(5, 1022);
            else
                capacity_value = $urandom_range(1, 4);

            write_setting(count_value, capacity_value);
            @(posedge clk);
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES)
                queue_random_name();

            // receiver stalls long while names keep coming, input must back up
            if (phase == PRESSURE_PHASE)
                hold_requests++;
            drain_phase();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d bytes in %0d names over %0d register settings",
                 bytes_accepted, names_queued, settings_used);
        $display("outcomes: %0d placed (%0d redirected), %0d rejected, %0d mismatches",
                 names_placed, names_redirected, names_rejected, error_count);
        if (error_count == 0 && expected_placements.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
src/dhsp_pkg.sv
src/dhsp_req_if.sv
src/dhsp_res_if.sv
src/dhsp_ctrl.sv
src/dhsp_datapath.sv
src/double_hash_server_placement_core.sv
tb/double_hash_server_placement_core_tb.sv
